/* rtl/ofr_pkg.sv */
// ----------------------------------------------------------------------------
// Orthonormal frame package
// Shared constants and the result coordinate type.
// ----------------------------------------------------------------------------
package ofr_pkg;
	localparam int AXES  = 3;
	localparam int OUT_W = 16;

	typedef logic signed [OUT_W-1:0] ofr_coord_t;
endpackage

/* rtl/orthonormal_frame_from_two_vectors.sv */
// ----------------------------------------------------------------------------
// Orthonormal frame from two vectors
// Returns the unit vectors of first, second cross first, and their cross
// product, each rounded to nearest in signed fixed point.
// ----------------------------------------------------------------------------
// The block takes one vector pair per cycle unless every stage is full and the
// output is stalled, and returns its frame after these stages: five stages form
// the cross products and squared lengths, then each of the nine components
// passes through a rounding lane that settles one quotient bit per stage, and
// a final register holds the result beat. Only a stalled output holds items
// back, and an empty stage anywhere lets the input side keep moving.
// Degenerate pairs give a zero frame with the degenerate flag set.
module orthonormal_frame_from_two_vectors #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ofr_pkg::ofr_coord_t          normal_x,
	output ofr_pkg::ofr_coord_t          normal_y,
	output ofr_pkg::ofr_coord_t          normal_z,
	output ofr_pkg::ofr_coord_t          side_x,
	output ofr_pkg::ofr_coord_t          side_y,
	output ofr_pkg::ofr_coord_t          side_z,
	output ofr_pkg::ofr_coord_t          up_x,
	output ofr_pkg::ofr_coord_t          up_y,
	output ofr_pkg::ofr_coord_t          up_z,
	output logic                         degenerate
);
	import ofr_pkg::*;

	localparam int FRONT = 5;
	localparam int TB    = FRAC_BITS+2;
	localparam int NST   = FRONT+TB+1;
	localparam int C     = COORD_BITS;
	localparam int SFW   = 2*C;
	localparam int SCW   = 4*C;
	localparam int SWW   = 6*C;

	logic [NST-1:0] v_q;
	logic [NST-1:0] v_in;
	logic [NST-1:0] en;

	for (genvar i = 0; i < NST; i++) begin : g_en
		assign en[i] = out_ready | ~(&v_q[NST-1:i]);
	end

	assign v_in = {v_q[NST-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (en[i]) begin
					v_q[i] <= v_in[i];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NST-1];

	logic signed [C-1:0] f_vec [AXES];
	logic signed [C-1:0] s_vec [AXES];

	always_comb begin
		f_vec[0] = first_x;
		f_vec[1] = first_y;
		f_vec[2] = first_z;
		s_vec[0] = second_x;
		s_vec[1] = second_y;
		s_vec[2] = second_z;
	end

	logic [SFW-1:0] fsq [AXES];
	logic [SFW-1:0] sf;
	logic [SCW-1:0] csq [AXES];
	logic [SCW-1:0] sc;
	logic [SWW-1:0] wsq [AXES];
	logic [SWW-1:0] sw;
	logic           f_neg [AXES];
	logic           c_neg [AXES];
	logic           w_neg [AXES];
	logic           deg;

	ofr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk   (clk),
		.en    (en[FRONT-1:0]),
		.f_in  (f_vec),
		.s_in  (s_vec),
		.fsq   (fsq),
		.sf    (sf),
		.csq   (csq),
		.sc    (sc),
		.wsq   (wsq),
		.sw    (sw),
		.f_neg (f_neg),
		.c_neg (c_neg),
		.w_neg (w_neg),
		.deg   (deg)
	);

	ofr_coord_t qn [AXES];
	ofr_coord_t qs [AXES];
	ofr_coord_t qu [AXES];

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		ofr_root #(
			.VAL_W(SFW), .FRAC_BITS(FRAC_BITS)
		) u_norm (
			.clk(clk), .en(en[FRONT+TB-1:FRONT]),
			.sq_in(fsq[a]), .norm_in(sf), .neg_in(f_neg[a]), .q(qn[a])
		);
		ofr_root #(
			.VAL_W(SCW), .FRAC_BITS(FRAC_BITS)
		) u_side (
			.clk(clk), .en(en[FRONT+TB-1:FRONT]),
			.sq_in(csq[a]), .norm_in(sc), .neg_in(c_neg[a]), .q(qs[a])
		);
		ofr_root #(
			.VAL_W(SWW), .FRAC_BITS(FRAC_BITS)
		) u_up (
			.clk(clk), .en(en[FRONT+TB-1:FRONT]),
			.sq_in(wsq[a]), .norm_in(sw), .neg_in(w_neg[a]), .q(qu[a])
		);
	end

	logic [TB-1:0] dg_s;

	always_ff @(posedge clk) begin
		for (int r = 0; r < TB; r++) begin
			if (en[FRONT+r]) begin
				dg_s[r] <= (r == 0) ? deg : dg_s[(r == 0) ? 0 : r-1];
			end
		end
	end

	ofr_coord_t nrm_q [AXES];
	ofr_coord_t sid_q [AXES];
	ofr_coord_t up_q  [AXES];
	logic       deg_q;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			deg_q <= dg_s[TB-1];
			for (int a = 0; a < AXES; a++) begin
				nrm_q[a] <= dg_s[TB-1] ? '0 : qn[a];
				sid_q[a] <= dg_s[TB-1] ? '0 : qs[a];
				up_q[a]  <= dg_s[TB-1] ? '0 : qu[a];
			end
		end
	end

	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];
	assign side_x     = sid_q[0];
	assign side_y     = sid_q[1];
	assign side_z     = sid_q[2];
	assign up_x       = up_q[0];
	assign up_y       = up_q[1];
	assign up_z       = up_q[2];
	assign degenerate = deg_q;

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input held off although the output stage is empty.");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&v_q) && !out_ready) |-> !in_ready)
		else $error("Input taken while every stage is full and stalled.");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_q[0])
		else $error("Accepted beat did not reach the first stage.");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (normal_x == '0 && normal_y == '0 &&
		normal_z == '0 && side_x == '0 && side_y == '0 && side_z == '0 &&
		up_x == '0 && up_y == '0 && up_z == '0))
		else $error("Degenerate beat carries a non-zero frame.");
endmodule

/* rtl/ofr_front.sv */
// ----------------------------------------------------------------------------
// Orthonormal frame front end
// Five stages that form the cross products, the squared lengths and the
// squared components that feed the rounding lanes.
// ----------------------------------------------------------------------------
module ofr_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic [4:0]                   en,
	input  logic signed [COORD_BITS-1:0] f_in   [ofr_pkg::AXES],
	input  logic signed [COORD_BITS-1:0] s_in   [ofr_pkg::AXES],
	output logic [2*COORD_BITS-1:0]      fsq    [ofr_pkg::AXES],
	output logic [2*COORD_BITS-1:0]      sf,
	output logic [4*COORD_BITS-1:0]      csq    [ofr_pkg::AXES],
	output logic [4*COORD_BITS-1:0]      sc,
	output logic [6*COORD_BITS-1:0]      wsq    [ofr_pkg::AXES],
	output logic [6*COORD_BITS-1:0]      sw,
	output logic                         f_neg  [ofr_pkg::AXES],
	output logic                         c_neg  [ofr_pkg::AXES],
	output logic                         w_neg  [ofr_pkg::AXES],
	output logic                         deg
);
	import ofr_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int HW  = 2*C;
	localparam int CW  = 2*C+1;
	localparam int SFW = 2*C;
	localparam int SCW = 4*C;
	localparam int WW  = 3*C+1;
	localparam int WMW = 3*C;
	localparam int WLO = WMW/2;
	localparam int WHI = WMW-WLO;
	localparam int SWW = 6*C;
	localparam int J [AXES] = '{1, 2, 0};
	localparam int K [AXES] = '{2, 0, 1};

	logic signed [C-1:0]  f_s1   [AXES];
	logic signed [CW-1:0] c_s1   [AXES];
	logic [SFW-1:0]       fsq_s1 [AXES];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < AXES; i++) begin
				f_s1[i]   <= f_in[i];
				c_s1[i]   <= CW'(s_in[J[i]]) * CW'(f_in[K[i]])
				           - CW'(s_in[K[i]]) * CW'(f_in[J[i]]);
				fsq_s1[i] <= SFW'(HW'(f_in[i]) * HW'(f_in[i]));
			end
		end
	end

	logic [HW-1:0]        c_mag  [AXES];
	logic [SFW-1:0]       sf_s2;
	logic [SFW-1:0]       fsq_s2 [AXES];
	logic [SCW-1:0]       csq_s2 [AXES];
	logic signed [WW-1:0] w_s2   [AXES];
	logic                 fn_s2  [AXES];
	logic                 cn_s2  [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			c_mag[i] = c_s1[i][CW-1] ? HW'(-c_s1[i]) : HW'(c_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sf_s2 <= fsq_s1[0] + fsq_s1[1] + fsq_s1[2];
			for (int i = 0; i < AXES; i++) begin
				fsq_s2[i] <= fsq_s1[i];
				csq_s2[i] <= c_mag[i] * c_mag[i];
				w_s2[i]   <= WW'(f_s1[J[i]]) * WW'(c_s1[K[i]])
				           - WW'(f_s1[K[i]]) * WW'(c_s1[J[i]]);
				fn_s2[i]  <= f_s1[i][C-1];
				cn_s2[i]  <= c_s1[i][CW-1];
			end
		end
	end

	logic [WMW-1:0]       w_mag  [AXES];
	logic [SFW-1:0]       sf_s3;
	logic [SCW-1:0]       sc_s3;
	logic [SFW-1:0]       fsq_s3 [AXES];
	logic [SCW-1:0]       csq_s3 [AXES];
	logic [2*WHI-1:0]     hh_s3  [AXES];
	logic [WHI+WLO-1:0]   hl_s3  [AXES];
	logic [2*WLO-1:0]     ll_s3  [AXES];
	logic                 fn_s3  [AXES];
	logic                 cn_s3  [AXES];
	logic                 wn_s3  [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			w_mag[i] = w_s2[i][WW-1] ? WMW'(-w_s2[i]) : WMW'(w_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sf_s3 <= sf_s2;
			sc_s3 <= csq_s2[0] + csq_s2[1] + csq_s2[2];
			for (int i = 0; i < AXES; i++) begin
				fsq_s3[i] <= fsq_s2[i];
				csq_s3[i] <= csq_s2[i];
				hh_s3[i]  <= w_mag[i][WMW-1:WLO] * w_mag[i][WMW-1:WLO];
				hl_s3[i]  <= w_mag[i][WMW-1:WLO] * w_mag[i][WLO-1:0];
				ll_s3[i]  <= w_mag[i][WLO-1:0] * w_mag[i][WLO-1:0];
				fn_s3[i]  <= fn_s2[i];
				cn_s3[i]  <= cn_s2[i];
				wn_s3[i]  <= w_s2[i][WW-1];
			end
		end
	end

	logic [SFW-1:0]   sf_s4;
	logic [SCW-1:0]   sc_s4;
	logic [SFW-1:0]   fsq_s4 [AXES];
	logic [SCW-1:0]   csq_s4 [AXES];
	logic [SWW-1:0]   wsq_s4 [AXES];
	logic [SFW+HW-1:0] swl_s4;
	logic [SFW+HW-1:0] swh_s4;
	logic             deg_s4;
	logic             fn_s4  [AXES];
	logic             cn_s4  [AXES];
	logic             wn_s4  [AXES];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sf_s4  <= sf_s3;
			sc_s4  <= sc_s3;
			swl_s4 <= sf_s3 * sc_s3[HW-1:0];
			swh_s4 <= sf_s3 * sc_s3[SCW-1:HW];
			deg_s4 <= (sc_s3 == '0);
			for (int i = 0; i < AXES; i++) begin
				fsq_s4[i] <= fsq_s3[i];
				csq_s4[i] <= csq_s3[i];
				wsq_s4[i] <= (SWW'(hh_s3[i]) << (2*WLO)) + (SWW'(hl_s3[i]) << (WLO+1))
				           + SWW'(ll_s3[i]);
				fn_s4[i]  <= fn_s3[i];
				cn_s4[i]  <= cn_s3[i];
				wn_s4[i]  <= wn_s3[i];
			end
		end
	end

	logic [SFW-1:0] sf_s5;
	logic [SCW-1:0] sc_s5;
	logic [SWW-1:0] sw_s5;
	logic [SFW-1:0] fsq_s5 [AXES];
	logic [SCW-1:0] csq_s5 [AXES];
	logic [SWW-1:0] wsq_s5 [AXES];
	logic           deg_s5;
	logic           fn_s5  [AXES];
	logic           cn_s5  [AXES];
	logic           wn_s5  [AXES];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sf_s5  <= sf_s4;
			sc_s5  <= sc_s4;
			sw_s5  <= SWW'(swl_s4) + (SWW'(swh_s4) << HW);
			deg_s5 <= deg_s4;
			for (int i = 0; i < AXES; i++) begin
				fsq_s5[i] <= fsq_s4[i];
				csq_s5[i] <= csq_s4[i];
				wsq_s5[i] <= wsq_s4[i];
				fn_s5[i]  <= fn_s4[i];
				cn_s5[i]  <= cn_s4[i];
				wn_s5[i]  <= wn_s4[i];
			end
		end
	end

	assign sf  = sf_s5;
	assign sc  = sc_s5;
	assign sw  = sw_s5;
	assign deg = deg_s5;
	assign fsq = fsq_s5;
	assign csq = csq_s5;
	assign wsq = wsq_s5;
	assign f_neg = fn_s5;
	assign c_neg = cn_s5;
	assign w_neg = wn_s5;
endmodule

/* rtl/ofr_root.sv */
// ----------------------------------------------------------------------------
// Orthonormal frame rounding lane
// Finds the rounded quotient of a component by the square root of a squared
// length, one result bit per stage, and applies the sign.
// ----------------------------------------------------------------------------
module ofr_root #(
	parameter int VAL_W     = 32,
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic [FRAC_BITS+1:0] en,
	input  logic [VAL_W-1:0]     sq_in,
	input  logic [VAL_W-1:0]     norm_in,
	input  logic                 neg_in,
	output ofr_pkg::ofr_coord_t  q
);
	import ofr_pkg::*;

	localparam int TB = FRAC_BITS+2;
	localparam int DW = VAL_W+2*FRAC_BITS+5;
	localparam int EW = (OUT_W > TB) ? OUT_W : TB;

	logic [DW-1:0] rem_s  [TB];
	logic [DW-1:0] p_s    [TB];
	logic [DW-1:0] norm_s [TB];
	logic [TB-1:0] t_s    [TB];
	logic          neg_s  [TB];

	for (genvar r = 0; r < TB; r++) begin : g_stage
		localparam int K = TB-1-r;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] p_in;
		logic [DW-1:0] nv_in;
		logic [TB-1:0] t_in;
		logic          n_in;
		logic [DW-1:0] delta;
		logic [DW:0]   diff;

		if (r == 0) begin : g_first
			assign rem_in = DW'(sq_in) << (2*(FRAC_BITS+1));
			assign p_in   = '0;
			assign nv_in  = DW'(norm_in);
			assign t_in   = '0;
			assign n_in   = neg_in;
		end else begin : g_next
			assign rem_in = rem_s[r-1];
			assign p_in   = p_s[r-1];
			assign nv_in  = norm_s[r-1];
			assign t_in   = t_s[r-1];
			assign n_in   = neg_s[r-1];
		end

		// Trying bit K: (t + 2^K)^2 * S grows by (2^(K+1) * t * S) + 4^K * S.
		assign delta = (p_in << (K+1)) + (nv_in << (2*K));
		assign diff  = {1'b0, rem_in} - {1'b0, delta};

		always_ff @(posedge clk) begin
			if (en[r]) begin
				norm_s[r] <= nv_in;
				neg_s[r]  <= n_in;
				if (!diff[DW]) begin
					rem_s[r] <= diff[DW-1:0];
					p_s[r]   <= p_in + (nv_in << K);
					t_s[r]   <= t_in | (TB'(1) << K);
				end else begin
					rem_s[r] <= rem_in;
					p_s[r]   <= p_in;
					t_s[r]   <= t_in;
				end
			end
		end
	end

	logic [EW-1:0] q_mag;
	logic [EW-1:0] q_val;

	always_comb begin
		q_mag = (EW'(t_s[TB-1]) + EW'(1)) >> 1;
		q_val = neg_s[TB-1] ? -q_mag : q_mag;
		q     = q_val[OUT_W-1:0];
	end
endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Orthonormal frame testbench
// Drives vector pairs with random gaps and a randomly stalled result side,
// predicts each frame with wide exact integer arithmetic and checks every
// result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb;
	import ofr_pkg::*;

	localparam int CB        = 16;
	localparam int FB        = 14;
	localparam int N_RANDOM  = 1530;
	localparam int LIMIT     = 600000;
	localparam int DRAIN     = 40;

	typedef logic signed [127:0] wide_t;
	typedef logic [255:0]        huge_t;

	typedef struct {
		ofr_coord_t normal[AXES];
		ofr_coord_t side[AXES];
		ofr_coord_t up[AXES];
		logic       degen;
	} frame_t;

	typedef logic signed [CB-1:0] coord_t;
	typedef coord_t vec_t[AXES];

	function automatic ofr_coord_t round_unit(wide_t x, huge_t len_sq);
		huge_t mag, rhs, k, t;
		int lo, hi, mid;
		mag = (x < 0) ? huge_t'(-x) : huge_t'(x);
		rhs = (mag * mag) << (2 * FB + 2);
		lo  = 0;
		hi  = 1 << FB;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			k   = huge_t'(2 * mid - 1);
			t   = k * k * len_sq;
			if (t <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return (x < 0) ? ofr_coord_t'(-lo) : ofr_coord_t'(lo);
	endfunction

	function automatic frame_t predict_frame(vec_t fv, vec_t sv);
		frame_t r;
		wide_t f[AXES], s[AXES], c[AXES], w[AXES];
		wide_t ff, cc, fs;
		huge_t prod;
		for (int i = 0; i < AXES; i++) begin
			f[i] = wide_t'(fv[i]);
			s[i] = wide_t'(sv[i]);
		end
		c[0] = s[1] * f[2] - s[2] * f[1];
		c[1] = s[2] * f[0] - s[0] * f[2];
		c[2] = s[0] * f[1] - s[1] * f[0];
		ff = f[0] * f[0] + f[1] * f[1] + f[2] * f[2];
		cc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		fs = f[0] * s[0] + f[1] * s[1] + f[2] * s[2];
		r.degen = (ff == 0) || (cc == 0);
		prod = huge_t'(ff) * huge_t'(cc);
		for (int i = 0; i < AXES; i++) begin
			w[i] = s[i] * ff - f[i] * fs;
			if (r.degen) begin
				r.normal[i] = '0;
				r.side[i]   = '0;
				r.up[i]     = '0;
			end else begin
				r.normal[i] = round_unit(f[i], huge_t'(ff));
				r.side[i]   = round_unit(c[i], huge_t'(cc));
				r.up[i]     = round_unit(w[i], prod);
			end
		end
		return r;
	endfunction

	class frame_scoreboard;
		frame_t pending[$];
		int     fails;

		function void note_pair(vec_t fv, vec_t sv);
			pending.push_back(predict_frame(fv, sv));
		endfunction

		function void check_frame(frame_t got);
			frame_t e;
			string ax[AXES] = '{"x", "y", "z"};
			if (pending.size() == 0) begin
				$error("result beat with no pair outstanding");
				fails++;
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < AXES; i++) begin
				if (got.normal[i] !== e.normal[i]) begin
					$error("normal_%s expected %0d got %0d", ax[i], e.normal[i], got.normal[i]);
					fails++;
				end
				if (got.side[i] !== e.side[i]) begin
					$error("side_%s expected %0d got %0d", ax[i], e.side[i], got.side[i]);
					fails++;
				end
				if (got.up[i] !== e.up[i]) begin
					$error("up_%s expected %0d got %0d", ax[i], e.up[i], got.up[i]);
					fails++;
				end
			end
			if (got.degen !== e.degen) begin
				$error("degenerate expected %0b got %0b", e.degen, got.degen);
				fails++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	coord_t first_x, first_y, first_z, second_x, second_y, second_z;
	ofr_coord_t normal_x, normal_y, normal_z, side_x, side_y, side_z, up_x, up_y, up_z;
	logic degenerate;

	frame_scoreboard sb;
	int  cycles;
	bit  send_idle, recv_idle;

	orthonormal_frame_from_two_vectors #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[orthonormal_frame_from_two_vectors] ERROR");
			$finish;
		end
	end

	task automatic send_pair(vec_t fv, vec_t sv);
		int gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		first_x  <= fv[0];
		first_y  <= fv[1];
		first_z  <= fv[2];
		second_x <= sv[0];
		second_y <= sv[1];
		second_z <= sv[2];
		in_valid <= 1'b1;
		@(negedge clk);
		while (!in_ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		sb.note_pair(fv, sv);
	endtask

	function automatic coord_t pick_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 16) - 8);
			default: begin
				case ($urandom_range(0, 4))
					0: return -32768;
					1: return 32767;
					2: return -32767;
					3: return 0;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	task automatic send_random;
		vec_t fv, sv;
		int kind, k, mode;
		kind = $urandom_range(0, 9);
		mode = $urandom_range(0, 2);
		for (int i = 0; i < AXES; i++) begin
			fv[i] = pick_coord(mode);
			sv[i] = pick_coord($urandom_range(0, 2));
		end
		if (kind == 0) begin
			k = $urandom_range(0, 6) - 3;
			for (int i = 0; i < AXES; i++) begin
				fv[i] = coord_t'($urandom_range(0, 20000) - 10000);
				sv[i] = coord_t'(fv[i] * k);
			end
		end else if (kind == 1) begin
			for (int i = 0; i < AXES; i++) fv[i] = '0;
		end else if (kind == 2) begin
			for (int i = 0; i < AXES; i++) sv[i] = fv[i];
			sv[$urandom_range(0, 2)] += 1;
		end
		send_pair(fv, sv);
	endtask

	task automatic send_directed;
		vec_t fv, sv;
		fv = '{1, 0, 0};          sv = '{0, 1, 0};          send_pair(fv, sv);
		fv = '{0, 0, 1};          sv = '{1, 0, 0};          send_pair(fv, sv);
		fv = '{0, 0, 0};          sv = '{1, 2, 3};          send_pair(fv, sv);
		fv = '{3, -4, 5};         sv = '{0, 0, 0};          send_pair(fv, sv);
		fv = '{0, 0, 0};          sv = '{0, 0, 0};          send_pair(fv, sv);
		fv = '{2, -3, 7};         sv = '{4, -6, 14};        send_pair(fv, sv);
		fv = '{2, -3, 7};         sv = '{-2, 3, -7};        send_pair(fv, sv);
		fv = '{-32768, -32768, -32768}; sv = '{32767, 32767, 32767}; send_pair(fv, sv);
		fv = '{-32768, -32768, -32768}; sv = '{-32768, 32767, -32768}; send_pair(fv, sv);
		fv = '{32767, -32768, 32767};   sv = '{-32768, 32767, 32767};  send_pair(fv, sv);
		fv = '{-32768, 0, 0};     sv = '{0, -32768, 0};     send_pair(fv, sv);
		fv = '{32767, 1, 0};      sv = '{32767, 0, 1};      send_pair(fv, sv);
		fv = '{1, 1, 0};          sv = '{0, 0, 1};          send_pair(fv, sv);
		fv = '{1, 1, 1};          sv = '{1, -1, 0};         send_pair(fv, sv);
		fv = '{3, 4, 0};          sv = '{0, 0, -5};         send_pair(fv, sv);
		fv = '{-1, -1, -1};       sv = '{-1, -1, 0};        send_pair(fv, sv);
		fv = '{1, 2, 2};          sv = '{2, 1, -2};         send_pair(fv, sv);
		fv = '{32767, 32767, 32766}; sv = '{32767, 32766, 32767}; send_pair(fv, sv);
	endtask

	always begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 99) == 0) recv_idle = !recv_idle;
			stall = recv_idle ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) begin
				@(posedge clk);
				@(negedge clk);
			end
			sb.check_frame('{normal: '{normal_x, normal_y, normal_z},
				side: '{side_x, side_y, side_z}, up: '{up_x, up_y, up_z},
				degen: degenerate});
			@(posedge clk);
		end
	end

	initial begin
		sb        = new;
		cycles    = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		{first_x, first_y, first_z, second_x, second_y, second_z} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 99) == 0) send_idle = !send_idle;
			if (n == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
			send_random();
		end
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.fails == 0) $display("[orthonormal_frame_from_two_vectors] OK");
		else $display("[orthonormal_frame_from_two_vectors] ERROR");
		$finish;
	end
endmodule

/* orthonormal_frame_from_two_vectors.f */
rtl/ofr_pkg.sv
rtl/ofr_front.sv
rtl/ofr_root.sv
rtl/orthonormal_frame_from_two_vectors.sv
verif/tb.sv
